### rtl/ssrc_pkg.sv
// Package for the spline sample rate converter: widths, codes, types and tap weights.
`default_nettype none

package ssrc_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  // Field and state widths
  localparam int SMP_W    = 24;
  localparam int PCM_W    = 16;
  localparam int STEP_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = IDX_W + FRAC_W;
  localparam int ACC_W    = 25;
  localparam int KW       = 9;                    // tap weight width
  localparam int TAPM_W   = KW + SMP_W;           // weight * sample
  localparam int COEF_W   = 34;                   // polynomial coefficients and Horner term
  localparam int PROD_W   = COEF_W + FRAC_W + 1;  // term * fraction
  localparam int NUM_W    = 36;
  localparam int DIVX_W   = 24;
  localparam int QPROD_W  = 2 * DIVX_W;
  localparam int DIV_SH   = 11;                   // 6144 = 3 * 2^11
  localparam int RECIP_SH = 25;

  localparam logic [ACC_W-1:0]  ONE_Q16    = ACC_W'(65536);
  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(65536);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(180634);
  localparam logic [DIVX_W-1:0] RECIP3     = DIVX_W'(24'hAAAAAB);
  localparam logic [PCM_W-1:0]  PCM_MAX    = 16'h7FFF;
  localparam logic [PCM_W-1:0]  PCM_MIN    = 16'h8000;

  // Sequencer limits
  localparam logic [2:0] NTAPS     = 3'd6;
  localparam logic [2:0] HOR_LAST  = 3'd4;
  localparam logic [2:0] COEF_E    = 3'd4;
  localparam logic [2:0] COEF_D    = 3'd3;
  localparam logic [2:0] TAP_CTR   = 3'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EN   = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPS,
    ST_HINIT,
    ST_MUL,
    ST_ADD,
    ST_DIV1,
    ST_DIV2
  } ctl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic       wr;        // write sample, advance phase
    logic       tap_rd;
    logic [2:0] tap_sel;
    logic       tap_acc;
    logic [2:0] acc_sel;
    logic       hor_init;
    logic       hor_mul;
    logic       hor_add;
    logic       hor_last;
    logic [2:0] hor_sel;
    logic       div1;
    logic       load;
  } ssrc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic out_busy;
  } ssrc_stat_t;

  // Weight of tap j (p0..p5) in coefficient c (0=A .. 4=E)
  function automatic logic signed [KW-1:0] tap_weight(input logic [2:0] c,
                                                       input logic [2:0] j);
    logic signed [KW-1:0] w;
    w = '0;
    case (c)
      3'd0: case (j)
        3'd0: w = 9'sd2;   3'd1: w = -9'sd16; 3'd3: w = 9'sd16;
        3'd4: w = -9'sd2;  default: w = '0;
      endcase
      3'd1: case (j)
        3'd0: w = -9'sd1;  3'd1: w = 9'sd16;  3'd2: w = -9'sd30;
        3'd3: w = 9'sd16;  3'd4: w = -9'sd1;  default: w = '0;
      endcase
      3'd2: case (j)
        3'd0: w = -9'sd9;  3'd1: w = 9'sd39;  3'd2: w = -9'sd70;
        3'd3: w = 9'sd66;  3'd4: w = -9'sd33; 3'd5: w = 9'sd7;
        default: w = '0;
      endcase
      3'd3: case (j)
        3'd0: w = 9'sd13;  3'd1: w = -9'sd64; 3'd2: w = 9'sd126;
        3'd3: w = -9'sd124; 3'd4: w = 9'sd61; 3'd5: w = -9'sd12;
        default: w = '0;
      endcase
      3'd4: case (j)
        3'd0: w = -9'sd5;  3'd1: w = 9'sd25;  3'd2: w = -9'sd50;
        3'd3: w = 9'sd50;  3'd4: w = -9'sd25; 3'd5: w = 9'sd5;
        default: w = '0;
      endcase
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/ssrc_smp_if.sv
// Input sample channel: valid/ready with one signed Q1.23 sample.
`default_nettype none

interface ssrc_smp_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssrc_pkg::SMP_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

`default_nettype wire

### rtl/ssrc_pcm_if.sv
// Output PCM channel: valid/ready with one signed 16-bit sample.
`default_nettype none

interface ssrc_pcm_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssrc_pkg::PCM_W-1:0] pcm_out;

  modport source (output valid, output pcm_out, input ready);
  modport sink   (input valid, input pcm_out, output ready);
endinterface

`default_nettype wire

### rtl/ssrc_ctrl.sv
// Sequencer for the converter: tap fetch, Horner steps, scaling and output load.
`default_nettype none

module ssrc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ssrc_pkg::ssrc_stat_t stat_i,
  output ssrc_pkg::ssrc_cmd_t     cmd_o
);

  ssrc_pkg::ctl_state_e state_q, state_d;
  logic [2:0]           cnt_q, cnt_d;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssrc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ssrc_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.emit) begin
          state_d = ssrc_pkg::ST_TAPS;
          cnt_d   = '0;
        end
      end
      ssrc_pkg::ST_TAPS: begin
        if (cnt_q == ssrc_pkg::NTAPS) begin
          state_d = ssrc_pkg::ST_HINIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ssrc_pkg::ST_HINIT: state_d = ssrc_pkg::ST_MUL;
      ssrc_pkg::ST_MUL:   state_d = ssrc_pkg::ST_ADD;
      ssrc_pkg::ST_ADD: begin
        if (cnt_q == ssrc_pkg::HOR_LAST) begin
          state_d = ssrc_pkg::ST_DIV1;
        end else begin
          state_d = ssrc_pkg::ST_MUL;
          cnt_d   = cnt_q + 3'd1;
        end
      end
      ssrc_pkg::ST_DIV1: state_d = ssrc_pkg::ST_DIV2;
      ssrc_pkg::ST_DIV2: begin
        if (!stat_i.out_busy) state_d = ssrc_pkg::ST_IDLE;
      end
      default: state_d = ssrc_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ssrc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.wr   = in_valid_i;
      end
      ssrc_pkg::ST_TAPS: begin
        cmd_o.tap_rd  = (cnt_q != ssrc_pkg::NTAPS);
        cmd_o.tap_sel = cnt_q;
        cmd_o.tap_acc = (cnt_q != 3'd0);
        cmd_o.acc_sel = cnt_q - 3'd1;
      end
      ssrc_pkg::ST_HINIT: cmd_o.hor_init = 1'b1;
      ssrc_pkg::ST_MUL:   cmd_o.hor_mul  = 1'b1;
      ssrc_pkg::ST_ADD: begin
        cmd_o.hor_add  = 1'b1;
        cmd_o.hor_last = (cnt_q == ssrc_pkg::HOR_LAST);
        cmd_o.hor_sel  = ssrc_pkg::COEF_D - cnt_q;
      end
      ssrc_pkg::ST_DIV1: cmd_o.div1 = 1'b1;
      ssrc_pkg::ST_DIV2: cmd_o.load = !stat_i.out_busy;
      default: ;
    endcase
  end

  // An emitting sample starts the tap fetch
  a_emit_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr && stat_i.emit) |=> (state_q == ssrc_pkg::ST_TAPS))
    else $error("emitting sample did not start tap fetch");

  a_tap_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssrc_pkg::ST_TAPS) |-> (cnt_q <= ssrc_pkg::NTAPS))
    else $error("tap counter out of range");

  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> ($past(state_q) == ssrc_pkg::ST_DIV1 ||
                    $past(state_q) == ssrc_pkg::ST_DIV2))
    else $error("output load without scaling step");

endmodule

`default_nettype wire

### rtl/ssrc_dpath.sv
// Datapath: sample ring, phase and read position, coefficient build, Horner and scaling.
`default_nettype none

module ssrc_dpath (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire ssrc_pkg::ssrc_cmd_t                   cmd_i,
  output ssrc_pkg::ssrc_stat_t                       stat_o,
  input  wire logic signed [ssrc_pkg::SMP_W-1:0]     in_sample_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ssrc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [ssrc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic signed [ssrc_pkg::PCM_W-1:0]          pcm_out_o
);

  localparam int IDX_W  = ssrc_pkg::IDX_W;
  localparam int FRAC_W = ssrc_pkg::FRAC_W;
  localparam int COEF_W = ssrc_pkg::COEF_W;

  // Configuration registers
  logic [ssrc_pkg::STEP_W-1:0] step_q;
  logic                        en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ssrc_pkg::STEP_RESET;
      en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssrc_pkg::REG_STEP: step_q <= cfg_data_i[ssrc_pkg::STEP_W-1:0];
        ssrc_pkg::REG_EN:   en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Phase accumulator and read position
  logic [ssrc_pkg::STEP_W-1:0] step_eff;
  logic [ssrc_pkg::ACC_W-1:0]  acc_q, acc_add;
  logic [ssrc_pkg::POS_W-1:0]  pos_q;
  logic [IDX_W-1:0]            wr_q, base_q;
  logic [FRAC_W-1:0]           frac_q;
  logic                        emit;

  assign step_eff = (step_q < ssrc_pkg::STEP_MIN) ? ssrc_pkg::STEP_MIN : step_q;
  assign acc_add  = acc_q + ssrc_pkg::ONE_Q16;
  assign emit     = en_q && (acc_add >= ssrc_pkg::ACC_W'(step_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
      wr_q  <= '0;
    end else if (cmd_i.wr) begin
      wr_q <= wr_q + IDX_W'(1);
      if (en_q) begin
        if (emit) begin
          acc_q <= acc_add - ssrc_pkg::ACC_W'(step_eff);
          pos_q <= pos_q + ssrc_pkg::POS_W'(step_eff);
        end else begin
          acc_q <= acc_add;
        end
      end
    end
  end

  // Position of the pending output
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && emit) begin
      base_q <= pos_q[ssrc_pkg::POS_W-1:FRAC_W];
      frac_q <= pos_q[FRAC_W-1:0];
    end
  end

  // Sample ring with per-entry valid bits (unwritten entries read as zero)
  logic [ssrc_pkg::SMP_W-1:0] ring_q [ssrc_pkg::RING_DEPTH];
  logic [ssrc_pkg::RING_DEPTH-1:0] vld_q;
  logic [ssrc_pkg::SMP_W-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic [IDX_W-1:0]           rd_addr;

  assign rd_addr = base_q + IDX_W'(cmd_i.tap_sel) - IDX_W'(2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) ring_q[wr_q] <= in_sample_i;
    if (cmd_i.tap_rd) rd_data_q <= ring_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr) vld_q[wr_q] <= 1'b1;
      if (cmd_i.tap_rd) rd_vld_q <= vld_q[rd_addr];
    end
  end

  // Coefficient build: one tap a cycle into all five coefficients
  logic signed [ssrc_pkg::SMP_W-1:0] tap_v;
  logic signed [COEF_W-1:0]          coef_q [5];
  logic signed [ssrc_pkg::SMP_W-1:0] p2_q;

  assign tap_v = rd_vld_q ? $signed(rd_data_q) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_acc) begin
      for (int k = 0; k < 5; k++) begin
        logic signed [ssrc_pkg::TAPM_W-1:0] m;
        m = ssrc_pkg::tap_weight(3'(k), cmd_i.acc_sel) * tap_v;
        coef_q[k] <= ((cmd_i.acc_sel == 3'd0) ? '0 : coef_q[k]) + COEF_W'(m);
      end
      if (cmd_i.acc_sel == ssrc_pkg::TAP_CTR) p2_q <= tap_v;
    end
  end

  // Horner evaluation in the fraction, multiply and add on separate cycles
  logic signed [COEF_W-1:0]           t_q;
  logic signed [ssrc_pkg::PROD_W-1:0] prod_q;
  logic signed [ssrc_pkg::PROD_W-1:0] prod_sh;

  assign prod_sh = prod_q >>> FRAC_W;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hor_init) t_q <= coef_q[ssrc_pkg::COEF_E];
    if (cmd_i.hor_mul)  prod_q <= t_q * $signed({1'b0, frac_q});
    if (cmd_i.hor_add) begin
      if (cmd_i.hor_last) t_q <= COEF_W'(prod_sh);
      else                t_q <= coef_q[cmd_i.hor_sel] + COEF_W'(prod_sh);
    end
  end

  // Scaling: divide by 6144 toward zero as (|num| >> 11) / 3 by reciprocal
  logic signed [ssrc_pkg::NUM_W-1:0] num;
  logic [ssrc_pkg::NUM_W-1:0]        mag;
  logic [ssrc_pkg::DIVX_W-1:0]       divx;
  logic [ssrc_pkg::QPROD_W-1:0]      qprod_q;
  logic                              neg_q;

  assign num  = (ssrc_pkg::NUM_W'(p2_q) <<< 4) + (ssrc_pkg::NUM_W'(p2_q) <<< 3)
              + ssrc_pkg::NUM_W'(t_q);
  assign mag  = num[ssrc_pkg::NUM_W-1] ? ssrc_pkg::NUM_W'(-num) : ssrc_pkg::NUM_W'(num);
  assign divx = mag[ssrc_pkg::DIV_SH +: ssrc_pkg::DIVX_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div1) begin
      qprod_q <= ssrc_pkg::QPROD_W'(divx) * ssrc_pkg::QPROD_W'(ssrc_pkg::RECIP3);
      neg_q   <= num[ssrc_pkg::NUM_W-1];
    end
  end

  // Saturation to 16 bits
  localparam int QMAG_W = ssrc_pkg::QPROD_W - ssrc_pkg::RECIP_SH;

  logic [QMAG_W-1:0]          qmag;
  logic [ssrc_pkg::PCM_W-1:0] pcm_d;

  assign qmag = qprod_q[ssrc_pkg::QPROD_W-1:ssrc_pkg::RECIP_SH];

  always_comb begin
    if (!neg_q) begin
      pcm_d = (qmag > QMAG_W'(ssrc_pkg::PCM_MAX)) ? ssrc_pkg::PCM_MAX
                                                  : ssrc_pkg::PCM_W'(qmag);
    end else begin
      pcm_d = (qmag > QMAG_W'(ssrc_pkg::PCM_MIN)) ? ssrc_pkg::PCM_MIN
                                                  : ssrc_pkg::PCM_W'(-qmag);
    end
  end

  // Output register
  logic out_v_q;
  logic [ssrc_pkg::PCM_W-1:0] pcm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) pcm_q <= pcm_d;
  end

  assign out_valid_o     = out_v_q;
  assign pcm_out_o       = $signed(pcm_q);
  assign stat_o.emit     = emit;
  assign stat_o.out_busy = out_v_q && !out_ready_i;

endmodule

`default_nettype wire

### rtl/spline_sample_rate_converter.sv
// Top level of the six-point spline sample rate converter.
//
//  channel   dir  handshake          payload
//  in_s      in   valid / ready      in_sample  signed 24 (Q1.23)
//  out_m     out  valid / ready      pcm_out    signed 16
//  cfg       in   cfg_we_i           cfg_idx_i (0 step, 1 enable), cfg_data_i 24
//
// A sample that yields no output is only accepted; one that yields an output is
// accepted and then passes through the ring reads (one port, six taps), the Horner
// steps on the shared multiplier, scaling and the output load. The sample ring reads
// as zero after reset through per-entry valid bits. A finished output waits in its
// register; only the next output load stalls on a full output register, and no
// sample is taken during that stall.
`default_nettype none

module spline_sample_rate_converter (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  ssrc_smp_if.sink                                  in_s,
  ssrc_pcm_if.source                                out_m,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ssrc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [ssrc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  ssrc_pkg::ssrc_cmd_t  cmd;
  ssrc_pkg::ssrc_stat_t stat;

  ssrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssrc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_sample_i (in_s.in_sample),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_m.ready),
    .out_valid_o (out_m.valid),
    .pcm_out_o   (out_m.pcm_out)
  );

endmodule

`default_nettype wire
